// File: sv/http_request_end_detector_defines.svh
// Assertion macros used by the request end detector top level.
`ifndef HTTP_REQUEST_END_DETECTOR_DEFINES_SVH
`define HTTP_REQUEST_END_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HRED_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hred: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HRED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hred: next-cycle check failed");

`endif

// File: sv/hred_pkg.sv
// Types, character codes and parser constants for the request end detector.
`default_nettype none

package hred_pkg;

   // Default width of the announced length and the body counter.
   localparam int LENGTH_WIDTH_DEF = 32;

   // Length of the header name "Content-Length:".
   localparam int NAME_LEN = 15;
   localparam int NAME_POS_WIDTH = $clog2(NAME_LEN + 1);

   // Value parsing phases.
   localparam logic [1:0] PHASE_IDLE  = 2'd0;
   localparam logic [1:0] PHASE_SKIP  = 2'd1;
   localparam logic [1:0] PHASE_BLANK = 2'd2;
   localparam logic [1:0] PHASE_DIGIT = 2'd3;

   // Header terminator progress.
   localparam logic [1:0] TERM_NONE  = 2'd0;
   localparam logic [1:0] TERM_LF    = 2'd1;
   localparam logic [1:0] TERM_LF_CR = 2'd2;

   // Character codes.
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // One request byte and its start marker.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_request;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic request_complete;
      logic headers_done;
      logic length_overflow;
   } rsp_word_type;

   // Expected character of the header name at a given position.
   function automatic logic [7:0] name_char(input logic [NAME_POS_WIDTH-1:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = "C";
         4'd1:    ch = "o";
         4'd2:    ch = "n";
         4'd3:    ch = "t";
         4'd4:    ch = "e";
         4'd5:    ch = "n";
         4'd6:    ch = "t";
         4'd7:    ch = "-";
         4'd8:    ch = "L";
         4'd9:    ch = "e";
         4'd10:   ch = "n";
         4'd11:   ch = "g";
         4'd12:   ch = "t";
         4'd13:   ch = "h";
         4'd14:   ch = ":";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Blank characters skipped ahead of the length digits.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) ||
             (c == CHAR_VT) || (c == CHAR_FF);
   endfunction

endpackage

`default_nettype wire

// File: sv/http_request_end_detector.sv
// Top level of the HTTP request end detector.
`default_nettype none
`include "http_request_end_detector_defines.svh"

// Takes one request byte per word and returns one result word per byte: whether this
// byte completes the request, whether the LF CR LF header terminator has been seen,
// and whether the Content-Length value saturated the LENGTH_WIDTH-bit counter. A new
// byte is accepted every cycle unless the input register holds a stalled byte. Its
// result word passes through the input register, then the parser's single pass loads
// the result register, from which it is offered. Throughput is one byte per clock
// whenever the consumer does not stall, and the parser state advances only when a
// byte moves into the result register.
// Set start_of_request on the first byte of each request to clear the parse state.
module http_request_end_detector #(
   parameter int LENGTH_WIDTH = hred_pkg::LENGTH_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire hred_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output hred_pkg::rsp_word_type     rsp_word
);

   logic                   s1_valid_ff, s1_valid_in;
   hred_pkg::req_word_type s1_word_ff;
   hred_pkg::rsp_word_type parse_result;
   logic                   advance;
   logic                   req_take;

   // The held byte moves on when the result register is free or being emptied.
   assign advance   = s1_valid_ff & (~rsp_valid | ~rsp_stall);
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   // Input register.
   assign s1_valid_in = req_take | (s1_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_word_ff <= req_word;
      end
   end

   // Parser state and next-state logic.
   hred_parse_core #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (s1_word_ff),
      .result (parse_result)
   );

   // Result register.
   hred_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_word (parse_result),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // A byte that moves into the result register is offered on the next cycle.
   `HRED_ASSERT_NEXT(a_advance_gives_rsp, clock, reset, advance, rsp_valid)
   // The input side stalls only while the result side holds a stalled word.
   `HRED_ASSERT_NOW(a_stall_cause, clock, reset, req_stall,
                    s1_valid_ff && rsp_valid && rsp_stall)
   // A completed request always reports its headers as done.
   `HRED_ASSERT_NOW(a_complete_has_headers, clock, reset,
                    rsp_valid && rsp_word.request_complete, rsp_word.headers_done)

endmodule

`default_nettype wire

// File: sv/hred_parse_core.sv
// Parser state and the single-pass next-state logic for one request byte.
`default_nettype none

module hred_parse_core #(
   parameter int LENGTH_WIDTH = hred_pkg::LENGTH_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire hred_pkg::req_word_type item,
   output hred_pkg::rsp_word_type     result
);

   localparam int PW = hred_pkg::NAME_POS_WIDTH;
   localparam int SW = LENGTH_WIDTH + 4;

   // State registers.
   logic                    line_start_ff, line_start_in;
   logic [PW-1:0]           name_pos_ff, name_pos_in;
   logic [1:0]              phase_ff, phase_in;
   logic [LENGTH_WIDTH-1:0] len_ff, len_in;
   logic                    len_given_ff, len_given_in;
   logic [1:0]              term_ff, term_in;
   logic                    in_body_ff, in_body_in;
   logic [LENGTH_WIDTH-1:0] remain_ff, remain_in;
   logic                    done_ff, done_in;
   logic                    ovf_ff, ovf_in;

   // State as seen by this byte, after an optional start of request.
   logic                    cur_line_start;
   logic [PW-1:0]           cur_name_pos;
   logic [1:0]              cur_phase;
   logic [LENGTH_WIDTH-1:0] cur_len;
   logic                    cur_len_given;
   logic [1:0]              cur_term;
   logic                    cur_in_body;
   logic [LENGTH_WIDTH-1:0] cur_remain;
   logic                    cur_done;
   logic                    cur_ovf;

   logic [7:0]    c;
   logic          is_digit;
   logic [SW-1:0] len_ext;
   logic [SW-1:0] digit_sum;
   logic          hdr_end;
   logic          complete;

   assign c = item.data_byte;

   // A start of request makes this byte see the reset state.
   always_comb begin
      if (item.start_of_request) begin
         cur_line_start = 1'b1;
         cur_name_pos   = '0;
         cur_phase      = hred_pkg::PHASE_IDLE;
         cur_len        = '0;
         cur_len_given  = 1'b0;
         cur_term       = hred_pkg::TERM_NONE;
         cur_in_body    = 1'b0;
         cur_remain     = '0;
         cur_done       = 1'b0;
         cur_ovf        = 1'b0;
      end else begin
         cur_line_start = line_start_ff;
         cur_name_pos   = name_pos_ff;
         cur_phase      = phase_ff;
         cur_len        = len_ff;
         cur_len_given  = len_given_ff;
         cur_term       = term_ff;
         cur_in_body    = in_body_ff;
         cur_remain     = remain_ff;
         cur_done       = done_ff;
         cur_ovf        = ovf_ff;
      end
   end

   // Next decimal value: len * 10 + digit, with a check of the carry bits.
   assign is_digit  = (c >= hred_pkg::CHAR_ZERO) && (c <= hred_pkg::CHAR_NINE);
   assign len_ext   = {4'b0000, cur_len};
   assign digit_sum = (len_ext << 3) + (len_ext << 1) + SW'(c[3:0]);

   // Terminator, header name, value and body count for this byte.
   always_comb begin
      line_start_in = cur_line_start;
      name_pos_in   = cur_name_pos;
      phase_in      = cur_phase;
      len_in        = cur_len;
      len_given_in  = cur_len_given;
      term_in       = cur_term;
      in_body_in    = cur_in_body;
      remain_in     = cur_remain;
      done_in       = cur_done;
      ovf_in        = cur_ovf;
      hdr_end       = 1'b0;
      complete      = 1'b0;

      if (cur_done) begin
         // Trailing bytes after completion are ignored.
      end else if (cur_in_body) begin
         remain_in = cur_remain - LENGTH_WIDTH'(1);
         if (cur_remain == LENGTH_WIDTH'(1)) begin
            in_body_in = 1'b0;
            done_in    = 1'b1;
            complete   = 1'b1;
         end
      end else begin
         // Header terminator LF CR LF.
         if (c == hred_pkg::CHAR_LF) begin
            hdr_end = (cur_term == hred_pkg::TERM_LF_CR);
            term_in = hred_pkg::TERM_LF;
         end else if ((c == hred_pkg::CHAR_CR) && (cur_term == hred_pkg::TERM_LF)) begin
            term_in = hred_pkg::TERM_LF_CR;
         end else begin
            term_in = hred_pkg::TERM_NONE;
         end

         // Header name match and value parsing.
         if (c == hred_pkg::CHAR_LF) begin
            line_start_in = 1'b1;
            name_pos_in   = '0;
            phase_in      = hred_pkg::PHASE_IDLE;
         end else if (cur_phase == hred_pkg::PHASE_SKIP) begin
            phase_in = hred_pkg::PHASE_BLANK;
         end else if (cur_phase == hred_pkg::PHASE_BLANK ||
                      cur_phase == hred_pkg::PHASE_DIGIT) begin
            if (is_digit) begin
               if (digit_sum[SW-1 -: 4] != 4'b0000) begin
                  len_in = '1;
                  ovf_in = 1'b1;
               end else begin
                  len_in = digit_sum[LENGTH_WIDTH-1:0];
               end
               phase_in = hred_pkg::PHASE_DIGIT;
            end else if (cur_phase == hred_pkg::PHASE_DIGIT || !hred_pkg::is_blank(c)) begin
               phase_in = hred_pkg::PHASE_IDLE;
            end
         end else if (cur_line_start) begin
            if ((cur_name_pos < PW'(hred_pkg::NAME_LEN)) &&
                (c == hred_pkg::name_char(cur_name_pos))) begin
               if (cur_name_pos == PW'(hred_pkg::NAME_LEN - 1)) begin
                  phase_in      = hred_pkg::PHASE_SKIP;
                  len_given_in  = 1'b1;
                  len_in        = '0;
                  ovf_in        = 1'b0;
                  line_start_in = 1'b0;
                  name_pos_in   = '0;
               end else begin
                  name_pos_in = cur_name_pos + PW'(1);
               end
            end else begin
               line_start_in = 1'b0;
               name_pos_in   = '0;
            end
         end

         // End of headers: start the body count or finish at once.
         if (hdr_end) begin
            term_in       = hred_pkg::TERM_NONE;
            line_start_in = 1'b0;
            phase_in      = hred_pkg::PHASE_IDLE;
            if (cur_len_given && (cur_len != '0)) begin
               in_body_in = 1'b1;
               remain_in  = cur_len;
            end else begin
               done_in  = 1'b1;
               complete = 1'b1;
            end
         end
      end
   end

   // Result word for this byte.
   always_comb begin
      result.request_complete = complete;
      result.headers_done     = in_body_in | done_in;
      result.length_overflow  = ovf_in;
   end

   // State update, one byte per step.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b1;
         name_pos_ff   <= '0;
         phase_ff      <= hred_pkg::PHASE_IDLE;
         len_ff        <= '0;
         len_given_ff  <= 1'b0;
         term_ff       <= hred_pkg::TERM_NONE;
         in_body_ff    <= 1'b0;
         remain_ff     <= '0;
         done_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
      end else if (step) begin
         line_start_ff <= line_start_in;
         name_pos_ff   <= name_pos_in;
         phase_ff      <= phase_in;
         len_ff        <= len_in;
         len_given_ff  <= len_given_in;
         term_ff       <= term_in;
         in_body_ff    <= in_body_in;
         remain_ff     <= remain_in;
         done_ff       <= done_in;
         ovf_ff        <= ovf_in;
      end
   end

endmodule

`default_nettype wire

// File: sv/hred_out_reg.sv
// Result register that holds a word until the consumer takes it.
`default_nettype none

module hred_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire hred_pkg::rsp_word_type load_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output hred_pkg::rsp_word_type     rsp_word
);

   logic                   valid_ff, valid_in;
   hred_pkg::rsp_word_type word_ff;

   // A load refills the register; otherwise a taken word empties it.
   assign valid_in = load ? 1'b1 : (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Word payload loads without reset.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= load_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

`default_nettype wire

// File: dv/tb_http_request_end_detector.sv
// Self-checking testbench for the HTTP request end detector.
`timescale 1ns / 1ps

module tb_http_request_end_detector;
   import hred_pkg::*;

   localparam int LENGTH_WIDTH = LENGTH_WIDTH_DEF;
   localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = '1;
   localparam logic [8*NAME_LEN-1:0] HEADER_TEXT = "Content-Length:";
   localparam int RANDOM_ITEMS = 1620;
   localparam int HOLD_OFF_LEN = 150;
   localparam int DRAIN_CYCLES = 4;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   // Expected result words, oldest first.
   rsp_word_type expected_flags[$];
   rsp_word_type want;
   int fail_count = 0;

   // Traffic shaping for the sender and the receiver.
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   int hold_off_cycles = 0;

   // Request under construction and the body length it announces.
   req_word_type request_words[$];
   int planned_body;

   // Parser state as the predictor sees it.
   logic                    at_line_start;
   logic [4:0]              name_pos;
   logic [1:0]              phase;
   logic [LENGTH_WIDTH-1:0] announced_len;
   logic                    len_seen;
   logic [1:0]              term_pos;
   logic                    counting_body;
   logic [LENGTH_WIDTH-1:0] body_left;
   logic                    finished;
   logic                    saturated;

   http_request_end_detector #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Predictor.

   function automatic void clear_parser();
      at_line_start = 1'b1;
      name_pos = '0;
      phase = PHASE_IDLE;
      announced_len = '0;
      len_seen = 1'b0;
      term_pos = TERM_NONE;
      counting_body = 1'b0;
      body_left = '0;
      finished = 1'b0;
      saturated = 1'b0;
   endfunction

   function automatic logic blank_char(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR ||
             c == CHAR_VT || c == CHAR_FF;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   // Accumulate one decimal digit, holding the value at the counter maximum.
   function automatic void add_digit(input logic [7:0] c);
      logic [63:0] acc;
      acc = {{(64-LENGTH_WIDTH){1'b0}}, announced_len} * 64'd10 + {56'd0, c - CHAR_ZERO};
      if (acc > {{(64-LENGTH_WIDTH){1'b0}}, LENGTH_MAX}) begin
         announced_len = LENGTH_MAX;
         saturated = 1'b1;
      end else begin
         announced_len = acc[LENGTH_WIDTH-1:0];
      end
   endfunction

   // Advance the parser by one request word and return the result word it causes.
   function automatic rsp_word_type advance_parser(input req_word_type w);
      logic [7:0] c;
      logic hdr_end;
      logic done_now;
      rsp_word_type r;
      c = w.data_byte;
      hdr_end = 1'b0;
      done_now = 1'b0;
      if (w.start_of_request) clear_parser();

      if (finished) begin
         // Trailing bytes after completion change nothing.
      end else if (counting_body) begin
         body_left = body_left - 1'b1;
         if (body_left == '0) begin
            counting_body = 1'b0;
            finished = 1'b1;
            done_now = 1'b1;
         end
      end else begin
         // Track the LF CR LF terminator.
         if (c == CHAR_LF) begin
            hdr_end = (term_pos == TERM_LF_CR);
            term_pos = TERM_LF;
         end else if (c == CHAR_CR && term_pos == TERM_LF) begin
            term_pos = TERM_LF_CR;
         end else begin
            term_pos = TERM_NONE;
         end

         // Match the header name and read its value.
         if (c == CHAR_LF) begin
            at_line_start = 1'b1;
            name_pos = '0;
            phase = PHASE_IDLE;
         end else if (phase == PHASE_SKIP) begin
            phase = PHASE_BLANK;
         end else if (phase == PHASE_BLANK) begin
            if (digit_char(c)) begin
               add_digit(c);
               phase = PHASE_DIGIT;
            end else if (!blank_char(c)) begin
               phase = PHASE_IDLE;
            end
         end else if (phase == PHASE_DIGIT) begin
            if (digit_char(c)) add_digit(c);
            else phase = PHASE_IDLE;
         end else if (at_line_start) begin
            if (name_pos < NAME_LEN && c == HEADER_TEXT[8*(NAME_LEN-1-name_pos) +: 8]) begin
               name_pos = name_pos + 1'b1;
               if (name_pos == NAME_LEN) begin
                  phase = PHASE_SKIP;
                  len_seen = 1'b1;
                  announced_len = '0;
                  saturated = 1'b0;
                  at_line_start = 1'b0;
                  name_pos = '0;
               end
            end else begin
               at_line_start = 1'b0;
               name_pos = '0;
            end
         end

         // End of headers: count the body or finish at once.
         if (hdr_end) begin
            term_pos = TERM_NONE;
            at_line_start = 1'b0;
            phase = PHASE_IDLE;
            if (len_seen && announced_len != '0) begin
               counting_body = 1'b1;
               body_left = announced_len;
            end else begin
               finished = 1'b1;
               done_now = 1'b1;
            end
         end
      end

      r.request_complete = done_now;
      r.headers_done = counting_body | finished;
      r.length_overflow = saturated;
      return r;
   endfunction

   // Request construction.

   function automatic void append_byte(input logic [7:0] b);
      req_word_type w;
      w.data_byte = b;
      w.start_of_request = 1'b0;
      request_words.push_back(w);
   endfunction

   function automatic void append_text(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endfunction

   // Line end: LF alone or CR LF.
   function automatic void append_eol(input bit with_cr);
      if (with_cr) append_byte(CHAR_CR);
      append_byte(CHAR_LF);
   endfunction

   function automatic void append_terminator();
      append_byte(CHAR_LF);
      append_byte(CHAR_CR);
      append_byte(CHAR_LF);
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 4))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         2:       return CHAR_CR;
         3:       return CHAR_VT;
         default: return CHAR_FF;
      endcase
   endfunction

   function automatic logic [7:0] pick_non_lf();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF) b = "?";
      return b;
   endfunction

   // One Content-Length line with random spacing, sign and digits.
   function automatic void append_length_line();
      logic [7:0] b;
      int n;
      int intended;
      intended = 0;
      append_text("Content-Length:");
      b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : CHAR_SPACE;
      append_byte(b);
      n = $urandom_range(0, 2);
      repeat (n) append_byte(pick_blank());
      if ($urandom_range(0, 7) == 0) append_byte($urandom_range(0, 1) ? "+" : "-");
      case ($urandom_range(0, 9))
         0: begin
            // Ten to fourteen digits, often more than the counter holds.
            append_byte(8'($urandom_range(CHAR_ZERO + 1, CHAR_NINE)));
            n = $urandom_range(9, 13);
            repeat (n) append_byte(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
            intended = $urandom_range(1, 4);
         end
         1: intended = 0;
         default: begin
            intended = $urandom_range(0, 24);
            append_text($sformatf("%0d", intended));
         end
      endcase
      if ($urandom_range(0, 3) == 0) append_text("x;");
      append_eol(1'($urandom_range(0, 1)));
      if (b == CHAR_LF) intended = 0;
      planned_body = intended;
   endfunction

   function automatic void build_random_request();
      int lines;
      int n;
      string name_text;
      request_words.delete();
      planned_body = 0;

      // Now and then a request of pure noise with stray start markers.
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(5, 30);
         repeat (n) begin
            case ($urandom_range(0, 3))
               0:       append_byte(CHAR_LF);
               1:       append_byte(CHAR_CR);
               default: append_byte(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 7) == 0) request_words[$].start_of_request = 1'b1;
         end
         return;
      end

      if ($urandom_range(0, 1)) begin
         append_text("GET / HTTP/1.1");
         append_eol(1'($urandom_range(0, 1)));
      end
      lines = $urandom_range(0, 3);
      repeat (lines) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: append_length_line();
            5: begin
               // Name with one character changed, or in lower case.
               if ($urandom_range(0, 1)) begin
                  name_text = "content-length:";
               end else begin
                  name_text = "Content-Length:";
                  name_text[$urandom_range(0, NAME_LEN - 1)] = pick_non_lf();
               end
               append_text(name_text);
               append_text(" 7");
               append_eol(1'($urandom_range(0, 1)));
            end
            6: begin
               // Name cut short by the end of the line.
               name_text = "Content-Length:";
               append_text(name_text.substr(0, $urandom_range(0, NAME_LEN - 2)));
               append_eol(1'($urandom_range(0, 1)));
            end
            7: begin
               // Tab between digits ends the value.
               append_text("Content-Length:");
               append_byte(CHAR_TAB);
               append_text("1");
               append_byte(CHAR_TAB);
               append_text("2");
               append_eol(1'($urandom_range(0, 1)));
               planned_body = 1;
            end
            default: begin
               n = $urandom_range(1, 10);
               repeat (n) append_byte(pick_non_lf());
               append_eol(1'($urandom_range(0, 1)));
            end
         endcase
      end

      // Header terminator, sometimes broken.
      if (request_words.size() == 0) append_byte(CHAR_LF);
      if ($urandom_range(0, 11) == 0) append_byte(CHAR_LF);
      else append_byte(CHAR_CR);
      append_byte(CHAR_LF);

      // Body, with a few trailing bytes now and then.
      n = planned_body + $urandom_range(0, 2);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
      request_words[0].start_of_request = ($urandom_range(0, 9) != 0);
   endfunction

   // Driving.

   // Offer one word after a random gap and wait until it is taken.
   task automatic send_word(input req_word_type w);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 10) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_flags.push_back(advance_parser(w));
   endtask

   task automatic send_request(input bit with_start);
      if (with_start) request_words[0].start_of_request = 1'b1;
      foreach (request_words[i]) send_word(request_words[i]);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Stop sending until every expected word has come back.
   task automatic wait_drain();
      release_req();
      while (expected_flags.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Receiver: a random stall ahead of each result, or a long hold-off on request.
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            n = rsp_idle_on ? $urandom_range(0, 10) : 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Compare each accepted result word with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_flags.size() == 0) begin
            $error("result word with no expectation waiting");
            fail_count++;
         end else begin
            want = expected_flags.pop_front();
            if (rsp_word.request_complete !== want.request_complete) begin
               $error("request_complete: expected %0b, actual %0b",
                      want.request_complete, rsp_word.request_complete);
               fail_count++;
            end
            if (rsp_word.headers_done !== want.headers_done) begin
               $error("headers_done: expected %0b, actual %0b",
                      want.headers_done, rsp_word.headers_done);
               fail_count++;
            end
            if (rsp_word.length_overflow !== want.length_overflow) begin
               $error("length_overflow: expected %0b, actual %0b",
                      want.length_overflow, rsp_word.length_overflow);
               fail_count++;
            end
         end
      end
   end

   // Tests.

   // Bare terminator completes at once; later bytes are ignored.
   task automatic test_header_end_only();
      request_words.delete();
      append_terminator();
      append_byte(8'h00);
      append_byte(8'hFF);
      send_request(1'b1);
   endtask

   // Every blank ahead of the digits, then a three-byte body and one trailing byte.
   task automatic test_body_count();
      request_words.delete();
      append_text("Content-Length: ");
      append_byte(CHAR_TAB);
      append_byte(CHAR_CR);
      append_byte(CHAR_VT);
      append_byte(CHAR_FF);
      append_text("3");
      append_terminator();
      append_byte(CHAR_LF);
      append_byte(CHAR_CR);
      append_byte(8'hFF);
      append_text("z");
      send_request(1'b1);
   endtask

   // A later header wins; a sign or no digits gives a length of zero.
   task automatic test_length_variants();
      request_words.delete();
      append_text("Content-Length: 9");
      append_byte(CHAR_LF);
      append_text("Content-Length:x-4");
      append_terminator();
      send_request(1'b1);

      request_words.delete();
      append_text("Content-Length:");
      append_byte(CHAR_LF);
      append_text("Content-Length: 2a");
      append_terminator();
      append_text("ab");
      send_request(1'b1);
   endtask

   // A saturated length, then the largest length that still fits.
   task automatic test_saturation();
      request_words.delete();
      append_text("Content-Length: 99999999999");
      append_byte(CHAR_LF);
      append_text("Host");
      append_terminator();
      append_text("abc");
      send_request(1'b1);

      request_words.delete();
      append_text("Content-Length: 4294967295");
      append_terminator();
      append_text("xy");
      send_request(1'b1);
   endtask

   // Long receiver hold-off while the sender keeps offering words.
   task automatic test_backpressure();
      wait_drain();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      hold_off_cycles = HOLD_OFF_LEN;
      request_words.delete();
      append_text("Host: example");
      append_eol(1'b1);
      append_text("Content-Length: 12");
      append_eol(1'b1);
      append_eol(1'b1);
      repeat (12) append_byte(8'($urandom_range(0, 255)));
      send_request(1'b1);
      wait_drain();
   endtask

   // Mostly well-formed requests with random content, plus noise.
   task automatic test_random_requests();
      int sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         build_random_request();
         send_request(1'b0);
         sent += request_words.size();
      end
   endtask

   initial begin
      clear_parser();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_header_end_only();
      test_body_count();
      test_length_variants();
      test_saturation();
      test_backpressure();
      test_random_requests();
      wait_drain();

      if (fail_count == 0 && expected_flags.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/hred_pkg.sv
sv/hred_parse_core.sv
sv/hred_out_reg.sv
sv/http_request_end_detector.sv
dv/tb_http_request_end_detector.sv
